// ----- design/fir64_pkg.sv -----
// Shared constants and coefficient function for the 64-tap FIR filter.
`timescale 1ns / 1ps
package fir64_pkg;

    localparam int DesignTaps = 64;
    localparam longint DecScale = 64'sd100000000;
    localparam int SampleW = 16;
    localparam int DigitW = 4;

    // first half of the symmetric design, in units of 1e-8
    localparam int HalfDesign [DesignTaps/2] = '{
        -30995, -79491, -89012, -43010, 51534,
        151232, 184793, 93461, -113637, -331563,
        -398011, -196547, 232788, 661611, 774692,
        373992, -434217, -1213514, -1401970, -670273,
        773860, 2160706, 2507625, 1212370, -1427440,
        -4109939, -4995590, -2588554, 3390254, 11618024,
        19541860, 24394961
    };

    // fixed-point coefficient of tap k, rounded to nearest, ties away from zero
    function automatic longint coef_at(input int k, input int frac_bits);
        int     idx;
        longint v;
        longint mag;
        longint q;
        if (k < 0 || k >= DesignTaps) begin
            return 64'sd0;
        end
        idx = (k < DesignTaps / 2) ? k : (DesignTaps - 1 - k);
        v   = longint'(HalfDesign[idx]);
        mag = (v < 0) ? -v : v;
        mag = mag * (64'sd1 <<< frac_bits);
        q   = (mag + DecScale / 2) / DecScale;
        return (v < 0) ? -q : q;
    endfunction

endpackage

// ----- design/fir_filter_64_tap_top.sv -----
// Digit-serial 64-tap FIR low-pass filter: sample window, shared MAC, output register.
//
// Input channel: i_valid / o_ready carry one signed 16-bit sample word
// (i_left_sample). Output channel: o_valid / i_ready carry one signed 16-bit
// filtered word (o_filtered_sample) for every input word.
// A word is taken only while the MAC is idle. The sample window (TAPS words)
// shifts the new word in, then rotates one word per tap while the coefficient
// of that tap is applied one 4-bit digit per cycle (a 16 x 5 bit product).
// The MAC work for one word therefore steps through every 4-bit digit of
// every tap's coefficient on the single digit multiplier.
// With a free output register the next word is taken only after the MAC
// work, the hold state and the return to the idle state.
// The result sits in an output register, so the next input word is taken
// while a result still waits; if the receiver stalls past the end of the
// next computation, the MAC holds its finished sum until the register frees.
// The hold state loads the output register and raises o_valid.
// Reset (i_rst_n low, synchronous) clears the window to zero, which makes
// samples before the first input count as zero, and drops any pending result.
// The sum is truncated toward zero and saturated to the 16-bit range.
`timescale 1ns / 1ps
module fir_filter_64_tap_top
    import fir64_pkg::*;
#(
    parameter int TAPS = 64,
    parameter int COEF_FRAC_BITS = 15
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic signed [SampleW-1:0] i_left_sample,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [SampleW-1:0] o_filtered_sample
);

    localparam int CoefW  = COEF_FRAC_BITS + 1;
    localparam int NDig   = (CoefW + DigitW - 1) / DigitW;
    localparam int PadW   = NDig * DigitW;
    localparam int DigCW  = (NDig > 1) ? $clog2(NDig) : 1;
    localparam int TapCW  = $clog2(TAPS);
    localparam int ProdW  = SampleW + DigitW + 1;
    localparam int AccW   = SampleW + CoefW + 9;

    localparam logic [DigCW-1:0] LastDig = DigCW'(NDig - 1);
    localparam logic [TapCW-1:0] LastTap = TapCW'(TAPS - 1);
    localparam logic signed [AccW-1:0] SatHi = AccW'(32767);
    localparam logic signed [AccW-1:0] SatLo = -AccW'(32768);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_HOLD
    } t_state;

    t_state                     r_state;
    logic signed [SampleW-1:0]  r_win [TAPS];
    logic [TapCW-1:0]           r_tap;
    logic [DigCW-1:0]           r_dig;
    logic signed [AccW-1:0]     r_acc;
    logic                       r_out_valid;
    logic signed [SampleW-1:0]  r_out;

    logic                       in_acc;
    logic                       out_free;
    logic signed [PadW-1:0]     coef_tab [TAPS];
    logic signed [PadW-1:0]     coef_pad;
    logic [DigitW-1:0]          dig;
    logic signed [DigitW:0]     dig_s;
    logic signed [ProdW-1:0]    prod;
    logic signed [AccW-1:0]     n_acc;
    logic signed [AccW-1:0]     q;
    logic signed [AccW-1:0]     qt;
    logic signed [SampleW-1:0]  y;

    // coefficients are fixed at elaboration
    for (genvar g = 0; g < TAPS; g++) begin : g_coef
        localparam logic signed [PadW-1:0] Coef = PadW'(coef_at(g, COEF_FRAC_BITS));
        assign coef_tab[g] = Coef;
    end

    assign o_ready           = (r_state == S_IDLE);
    assign in_acc            = i_valid && o_ready;
    assign o_valid           = r_out_valid;
    assign o_filtered_sample = r_out;
    assign out_free          = !r_out_valid || i_ready;

    always_comb begin
        coef_pad = coef_tab[r_tap];
        dig      = coef_pad[int'(r_dig) * DigitW +: DigitW];
        // top digit carries the sign
        dig_s    = {(r_dig == LastDig) & dig[DigitW-1], dig};
        prod     = r_win[0] * dig_s;
        n_acc    = r_acc + (AccW'(prod) <<< (int'(r_dig) * DigitW));
        // truncate toward zero
        q        = r_acc >>> COEF_FRAC_BITS;
        qt       = q;
        if (r_acc[AccW-1] && (r_acc[COEF_FRAC_BITS-1:0] != '0)) begin
            qt = q + AccW'(1);
        end
        if (qt > SatHi) begin
            y = SampleW'(SatHi);
        end else if (qt < SatLo) begin
            y = SampleW'(SatLo);
        end else begin
            y = qt[SampleW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tap       <= '0;
            r_dig       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < TAPS; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            // the hold state reloads the register itself
            if (r_out_valid && i_ready && (r_state != S_HOLD)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        // shift the new word in, drop the oldest
                        for (int i = TAPS - 1; i > 0; i--) begin
                            r_win[i] <= r_win[i-1];
                        end
                        r_win[0] <= i_left_sample;
                        r_acc    <= '0;
                        r_tap    <= '0;
                        r_dig    <= '0;
                        r_state  <= S_CALC;
                    end
                end
                S_CALC: begin
                    r_acc <= n_acc;
                    if (r_dig == LastDig) begin
                        r_dig <= '0;
                        // advance to the next tap
                        for (int i = 0; i < TAPS - 1; i++) begin
                            r_win[i] <= r_win[i+1];
                        end
                        r_win[TAPS-1] <= r_win[0];
                        if (r_tap == LastTap) begin
                            r_tap   <= '0;
                            r_state <= S_HOLD;
                        end else begin
                            r_tap <= r_tap + TapCW'(1);
                        end
                    end else begin
                        r_dig <= r_dig + DigCW'(1);
                    end
                end
                S_HOLD: begin
                    if (out_free) begin
                        r_out       <= y;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // no second word while a computation runs
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_ready)
        else $error("input taken while MAC busy");

    // a result appears only out of the hold state
    a_out_from_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_HOLD))
        else $error("result loaded outside hold");

    // counters rest at zero when idle
    a_idle_counters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_tap == '0 && r_dig == '0))
        else $error("counters not cleared at idle");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> r_out_valid && $stable(r_out))
        else $error("pending result lost");

endmodule

// ----- bench/fir_filter_64_tap_top_test.sv -----
// Self-checking bench for the 64-tap FIR filter: random samples in, predicted filtered words out.
`timescale 1ns / 1ps
module fir_filter_64_tap_top_test;
    import fir64_pkg::*;

    localparam int Taps = 64;
    localparam int FracBits = 15;
    localparam int MacCycles = Taps * ((FracBits + 4) / 4);
    localparam int RandomWords = 2000;
    localparam longint CycleLimit = 64'd3000000;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    logic signed [SampleW-1:0] i_left_sample;
    logic o_valid;
    logic i_ready;
    logic signed [SampleW-1:0] o_filtered_sample;

    fir_filter_64_tap_top #(.TAPS(Taps), .COEF_FRAC_BITS(FracBits)) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_left_sample(i_left_sample),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_filtered_sample(o_filtered_sample)
    );

    logic signed [SampleW-1:0] pending_samples[$];
    logic signed [SampleW-1:0] expected_outputs[$];
    logic signed [SampleW-1:0] history[Taps-1];
    longint tap_coef[Taps];
    int fail_count = 0;
    int send_wait;
    int recv_wait;
    bit stim_done;
    longint cycle_count;
    logic in_taken;
    logic out_taken;

    // predict one filtered word and advance the sample history
    function automatic logic signed [SampleW-1:0] filter_word(
        input logic signed [SampleW-1:0] x);
        longint acc;
        longint q;
        acc = tap_coef[0] * longint'(x);
        for (int k = 1; k < Taps; k++) begin
            acc += tap_coef[k] * longint'(history[k-1]);
        end
        q = (acc < 0) ? -((-acc) >>> FracBits) : (acc >>> FracBits);
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        for (int k = Taps - 2; k > 0; k--) begin
            history[k] = history[k-1];
        end
        history[0] = x;
        return q[SampleW-1:0];
    endfunction

    // design values times 2^FracBits, rounded half away from zero
    function automatic longint scaled_coef(input int k);
        int idx;
        longint v;
        longint mag;
        idx = (k < Taps / 2) ? k : (Taps - 1 - k);
        v = longint'(HalfDesign[idx]);
        mag = (v < 0) ? -v : v;
        mag = (mag * (64'sd1 <<< FracBits) + 64'sd50000000) / 64'sd100000000;
        return (v < 0) ? -mag : mag;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
    end

    initial begin
        int run;
        logic signed [SampleW-1:0] rail;
        stim_done = 1'b0;
        for (int k = 0; k < Taps; k++) tap_coef[k] = scaled_coef(k);
        for (int k = 0; k < Taps - 1; k++) history[k] = '0;
        // impulse, then short full-scale runs of both signs
        pending_samples.push_back(16'sd32767);
        for (int k = 0; k < 4; k++) pending_samples.push_back(16'sd0);
        for (int k = 0; k < 8; k++) pending_samples.push_back(16'sh8000);
        for (int k = 0; k < 8; k++) pending_samples.push_back(16'sd32767);
        pending_samples.push_back(-16'sd1);
        pending_samples.push_back(16'sd1);
        pending_samples.push_back(-16'sd1);
        while (pending_samples.size() < RandomWords + 24) begin
            case ($urandom_range(0, 3))
                0: begin
                    // long constant run drives the output toward the rails
                    run = $urandom_range(20, 70);
                    rail = $urandom_range(0, 1) ? 16'sd32767 : 16'sh8000;
                    repeat (run) pending_samples.push_back(rail);
                end
                1: pending_samples.push_back($urandom_range(0, 1) ?
                    16'sd32767 : 16'sh8000);
                default: pending_samples.push_back(SampleW'($urandom));
            endcase
        end
        stim_done = 1'b1;
    end

    // accepts seen at the rising edge, used by both drivers at the falling edge
    always @(posedge i_clk) begin
        in_taken <= i_valid && o_ready;
        out_taken <= o_valid && i_ready;
    end

    // input driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_left_sample <= '0;
            send_wait <= $urandom_range(0, 3);
        end else if (i_valid && !in_taken) begin
            // hold until accepted
        end else if (send_wait > 0) begin
            i_valid <= 1'b0;
            send_wait <= send_wait - 1;
        end else if (stim_done && pending_samples.size() > 0) begin
            i_left_sample <= pending_samples[0];
            expected_outputs.push_back(filter_word(pending_samples.pop_front()));
            i_valid <= 1'b1;
            send_wait <= $urandom_range(0, 3);
        end else begin
            i_valid <= 1'b0;
        end
    end

    // output side: each word waits a drawn number of cycles before ready
    always @(negedge i_clk) begin
        int w;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            recv_wait <= $urandom_range(0, 3);
        end else begin
            w = out_taken ? int'($urandom_range(0, 3)) : recv_wait;
            if (w > 0) begin
                i_ready <= 1'b0;
                recv_wait <= o_valid ? w - 1 : w;
            end else begin
                i_ready <= 1'b1;
                recv_wait <= 0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        logic signed [SampleW-1:0] want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_outputs.size() == 0) begin
                $error("filtered_sample: no word expected, got %0d", o_filtered_sample);
                fail_count <= fail_count + 1;
            end else begin
                want = expected_outputs.pop_front();
                if (o_filtered_sample !== want) begin
                    $error("filtered_sample: expected %0d, actual %0d",
                        want, o_filtered_sample);
                    fail_count <= fail_count + 1;
                end
            end
        end
    end

    // end of run and timeout
    initial begin
        cycle_count = 0;
        wait (stim_done);
        while ((pending_samples.size() > 0 || i_valid || expected_outputs.size() > 0)
                && cycle_count < CycleLimit) begin
            @(posedge i_clk);
            cycle_count++;
        end
        if (cycle_count >= CycleLimit) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            repeat (MacCycles + 8) @(posedge i_clk);
            if (fail_count == 0 && expected_outputs.size() == 0) begin
                $display("Regression PASS");
            end else begin
                $display("Regression FAIL");
            end
            $finish;
        end
    end

endmodule

// ----- filelist.f -----
design/fir64_pkg.sv
design/fir_filter_64_tap_top.sv
bench/fir_filter_64_tap_top_test.sv
